// ===== rtl/ordered_array_table_defines.svh =====
// Assertion macros for the ordered array table RTL.
// Used by rtl/ordered_array_table.sv; expects signals named clock and reset in scope.
`ifndef ORDERED_ARRAY_TABLE_DEFINES_SVH
`define ORDERED_ARRAY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked after reset is released
`define OAT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ordered_array_table: assertion failed");

// Checked on every edge, including while reset is held
`define OAT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("ordered_array_table: assertion failed");

`else

`define OAT_ASSERT(lbl, prop)
`define OAT_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/oat_pkg.sv =====
// Types and constants shared by the ordered array table RTL.
// No dependencies.
`timescale 1ns / 1ps

package oat_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 7;
   localparam int IDX_W    = 7;
   localparam int WORD_W   = 32;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CMP_W-1:0]         cmp_type;
   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_SEARCH = 3'd3,
      OP_READ   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      RSP_OK   = 2'd0,
      RSP_BAD  = 2'd1,
      RSP_MISS = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

endpackage

// ===== rtl/ordered_array_table.sv =====
// Ordered array table: packed array of signed words with insert, delete, search and read.
// Depends on rtl/oat_pkg.sv and rtl/ordered_array_table_defines.svh.
`timescale 1ns / 1ps
`include "ordered_array_table_defines.svh"

// A request is one transaction on req_*; it answers with one or more transactions on
// rsp_*, the final one flagged by rsp_last. The entries live in a single-port-write,
// single-port-read memory and a small sequencer walks it one address per cycle while no
// result waits on rsp_stall, so one request is worked at a time and req_stall stays high
// until it is finished. Clear, rejected insert/delete, a delete of the top entry and an
// empty search or read answer straight from idle; an insert at the end goes to the final
// step; other inserts shift the entries up from the position and other deletes shift them
// down onto it, and a search walks every entry, before the final step; a read answers each
// entry as it walks and has no final step. The walk does at most one read and one write of
// the memory a cycle. A result that waits on rsp_stall holds a search or read walk and the final step.
module ordered_array_table (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_type,
   input  logic [6:0]              req_position,
   input  logic signed [31:0]      req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [6:0]              rsp_index,
   output logic signed [31:0]      rsp_entry_value,
   output logic                    rsp_has_entry,
   output logic                    rsp_last
);

   oat_pkg::word_type   entries_mem [oat_pkg::CAPACITY];

   oat_pkg::state_type  state_ff, state_in;
   oat_pkg::op_type     op_ff, op_in;
   oat_pkg::cnt_type    cnt_ff, cnt_in;
   oat_pkg::addr_type   cur_ff, cur_in;
   oat_pkg::addr_type   end_ff, end_in;
   oat_pkg::addr_type   pos_ff, pos_in;
   oat_pkg::addr_type   pend_addr_ff, pend_addr_in;
   oat_pkg::addr_type   hit_idx_ff, hit_idx_in;
   oat_pkg::word_type   val_ff, val_in;
   oat_pkg::word_type   rd_data_ff;
   logic                more_ff, more_in;
   logic                pend_ff, pend_in;
   logic                hit_ff, hit_in;

   logic                   rsp_valid_ff;
   oat_pkg::status_type    rsp_status_ff;
   oat_pkg::idx_type       rsp_index_ff;
   oat_pkg::word_type      rsp_entry_value_ff;
   logic                   rsp_has_entry_ff;
   logic                   rsp_last_ff;

   logic                   push;
   oat_pkg::status_type    push_status;
   oat_pkg::idx_type       push_index;
   oat_pkg::word_type      push_value;
   logic                   push_has;
   logic                   push_last;

   logic                   rd_en;
   oat_pkg::addr_type      rd_addr;
   logic                   wr_en;
   oat_pkg::addr_type      wr_addr;
   oat_pkg::word_type      wr_data;

   logic                   out_free;
   logic                   accept;
   logic                   consume;
   logic                   advance;
   logic                   match;
   oat_pkg::op_type        req_op;
   oat_pkg::cmp_type       pos_c;
   oat_pkg::cmp_type       cnt_c;
   oat_pkg::cmp_type       cap_c;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != oat_pkg::ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign req_op    = oat_pkg::op_type'(req_type);
   assign pos_c     = oat_pkg::cmp_type'(req_position);
   assign cnt_c     = oat_pkg::cmp_type'(cnt_ff);
   assign cap_c     = oat_pkg::cmp_type'(oat_pkg::CAPACITY);
   assign match     = (rd_data_ff == val_ff);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      pos_in       = pos_ff;
      pend_addr_in = pend_addr_ff;
      hit_idx_in   = hit_idx_ff;
      val_in       = val_ff;
      more_in      = more_ff;
      pend_in      = pend_ff;
      hit_in       = hit_ff;

      push        = 1'b0;
      push_status = oat_pkg::RSP_OK;
      push_index  = '0;
      push_value  = '0;
      push_has    = 1'b0;
      push_last   = 1'b1;

      rd_en   = 1'b0;
      rd_addr = cur_ff;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rd_data_ff;
      consume = 1'b0;
      advance = 1'b0;

      unique case (state_ff)
         oat_pkg::ST_IDLE: begin
            if (accept) begin
               op_in   = req_op;
               val_in  = req_value;
               pend_in = 1'b0;
               hit_in  = 1'b0;
               more_in = 1'b1;
               unique case (req_op)
                  oat_pkg::OP_CLEAR: begin
                     cnt_in = '0;
                     push   = 1'b1;
                  end
                  oat_pkg::OP_INSERT: begin
                     if (pos_c > cnt_c || cnt_c >= cap_c) begin
                        push        = 1'b1;
                        push_status = oat_pkg::RSP_BAD;
                        push_index  = oat_pkg::idx_type'(cnt_ff);
                     end else begin
                        pos_in = oat_pkg::addr_type'(req_position);
                        // appending needs no shift
                        if (pos_c == cnt_c) begin
                           state_in = oat_pkg::ST_FINAL;
                        end else begin
                           cur_in   = oat_pkg::addr_type'(cnt_ff - oat_pkg::cnt_type'(1));
                           end_in   = oat_pkg::addr_type'(req_position);
                           state_in = oat_pkg::ST_SCAN;
                        end
                     end
                  end
                  oat_pkg::OP_DELETE: begin
                     if (pos_c >= cnt_c) begin
                        push        = 1'b1;
                        push_status = oat_pkg::RSP_BAD;
                        push_index  = oat_pkg::idx_type'(cnt_ff);
                     end else if (pos_c + oat_pkg::cmp_type'(1) == cnt_c) begin
                        // removing the top entry needs no shift
                        cnt_in     = cnt_ff - oat_pkg::cnt_type'(1);
                        push       = 1'b1;
                        push_index = oat_pkg::idx_type'(cnt_in);
                     end else begin
                        cur_in   = oat_pkg::addr_type'(pos_c + oat_pkg::cmp_type'(1));
                        end_in   = oat_pkg::addr_type'(cnt_ff - oat_pkg::cnt_type'(1));
                        state_in = oat_pkg::ST_SCAN;
                     end
                  end
                  oat_pkg::OP_SEARCH, oat_pkg::OP_READ: begin
                     if (cnt_ff == '0) begin
                        push        = 1'b1;
                        push_status = (req_op == oat_pkg::OP_SEARCH) ?
                                      oat_pkg::RSP_MISS : oat_pkg::RSP_OK;
                     end else begin
                        cur_in   = '0;
                        end_in   = oat_pkg::addr_type'(cnt_ff - oat_pkg::cnt_type'(1));
                        state_in = oat_pkg::ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         oat_pkg::ST_SCAN: begin
            // rd_data_ff holds entry pend_addr_ff when pend_ff is set
            unique case (op_ff)
               oat_pkg::OP_INSERT: begin
                  consume = pend_ff;
                  wr_en   = pend_ff;
                  wr_addr = pend_addr_ff + oat_pkg::addr_type'(1);
               end
               oat_pkg::OP_DELETE: begin
                  consume = pend_ff;
                  wr_en   = pend_ff;
                  wr_addr = pend_addr_ff - oat_pkg::addr_type'(1);
               end
               oat_pkg::OP_SEARCH: begin
                  // a match is held back until the next one shows whether it is the last
                  consume = pend_ff && (!(match && hit_ff) || out_free);
                  if (consume && match) begin
                     push       = hit_ff;
                     push_index = oat_pkg::idx_type'(hit_idx_ff);
                     push_has   = 1'b1;
                     push_last  = 1'b0;
                     hit_in     = 1'b1;
                     hit_idx_in = pend_addr_ff;
                  end
               end
               oat_pkg::OP_READ: begin
                  consume    = pend_ff && out_free;
                  push       = consume;
                  push_index = oat_pkg::idx_type'(pend_addr_ff);
                  push_value = rd_data_ff;
                  push_has   = 1'b1;
                  push_last  = !more_ff;
               end
               default: consume = pend_ff;
            endcase

            advance = !pend_ff || consume;
            if (advance) begin
               if (more_ff) begin
                  rd_en        = 1'b1;
                  pend_in      = 1'b1;
                  pend_addr_in = cur_ff;
                  if (cur_ff == end_ff) begin
                     more_in = 1'b0;
                  end else if (op_ff == oat_pkg::OP_INSERT) begin
                     cur_in = cur_ff - oat_pkg::addr_type'(1);
                  end else begin
                     cur_in = cur_ff + oat_pkg::addr_type'(1);
                  end
               end else begin
                  pend_in  = 1'b0;
                  state_in = (op_ff == oat_pkg::OP_READ) ? oat_pkg::ST_IDLE : oat_pkg::ST_FINAL;
               end
            end
         end

         oat_pkg::ST_FINAL: begin
            if (out_free) begin
               state_in = oat_pkg::ST_IDLE;
               push     = 1'b1;
               unique case (op_ff)
                  oat_pkg::OP_INSERT: begin
                     wr_en      = 1'b1;
                     wr_addr    = pos_ff;
                     wr_data    = val_ff;
                     cnt_in     = cnt_ff + oat_pkg::cnt_type'(1);
                     push_index = oat_pkg::idx_type'(cnt_in);
                  end
                  oat_pkg::OP_DELETE: begin
                     cnt_in     = cnt_ff - oat_pkg::cnt_type'(1);
                     push_index = oat_pkg::idx_type'(cnt_in);
                  end
                  oat_pkg::OP_SEARCH: begin
                     if (hit_ff) begin
                        push_index = oat_pkg::idx_type'(hit_idx_ff);
                        push_has   = 1'b1;
                     end else begin
                        push_status = oat_pkg::RSP_MISS;
                        push_index  = oat_pkg::idx_type'(cnt_ff);
                     end
                  end
                  default: push = 1'b0;
               endcase
            end
         end

         default: state_in = oat_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= oat_pkg::ST_IDLE;
         cnt_ff       <= '0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         more_ff  <= more_in;
         pend_ff  <= pend_in;
         hit_ff   <= hit_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cur_ff       <= cur_in;
      end_ff       <= end_in;
      pos_ff       <= pos_in;
      pend_addr_ff <= pend_addr_in;
      hit_idx_ff   <= hit_idx_in;
      val_ff       <= val_in;
      if (push) begin
         rsp_status_ff      <= push_status;
         rsp_index_ff       <= push_index;
         rsp_entry_value_ff <= push_value;
         rsp_has_entry_ff   <= push_has;
         rsp_last_ff        <= push_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_index       = rsp_index_ff;
   assign rsp_entry_value = rsp_entry_value_ff;
   assign rsp_has_entry   = rsp_has_entry_ff;
   assign rsp_last        = rsp_last_ff;

   `OAT_ASSERT(a_count_in_range, cnt_ff <= oat_pkg::cnt_type'(oat_pkg::CAPACITY))
   `OAT_ASSERT(a_no_rw_collision, (wr_en && rd_en) |-> (wr_addr != rd_addr))
   `OAT_ASSERT(a_read_live_entry, pend_ff |-> (oat_pkg::cnt_type'(pend_addr_ff) < cnt_ff))
   `OAT_ASSERT(a_count_held_in_scan, (state_ff == oat_pkg::ST_SCAN) |=> $stable(cnt_ff))
   `OAT_ASSERT_ALWAYS(a_no_push_on_busy, (rsp_valid_ff && rsp_stall) |-> !push)

endmodule
